>>> sv/lir_pkg.sv
`default_nettype none

package lir_pkg;

    // sample width, Q1.15 by default
    localparam int unsigned SAMPLE_BITS = 16;
    // default step limit, ratio either way
    localparam int unsigned MAX_RATIO   = 16;
    // phase_step register width, unsigned Q5.16
    localparam int unsigned CFG_BITS    = 21;
    localparam int unsigned FRAC_BITS   = 16;
    localparam int unsigned ONE_Q16     = 65536;
    localparam int unsigned STEP_RESET  = 65536;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          stream_last;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          run_last;
        logic                          stream_done;
    } out_item_t;

endpackage

`default_nettype wire

>>> sv/lir_interp.sv
`default_nettype none

// Interpolation unit: product registered, rounding on the way out.
// value = round((1-f)*a + f*b) = round(a + f*(b-a)), ties toward +inf.
module lir_interp (
    input  wire logic                                   clk,
    input  wire logic                                   load,
    input  wire logic signed [lir_pkg::SAMPLE_BITS-1:0] a,
    input  wire logic signed [lir_pkg::SAMPLE_BITS-1:0] b,
    input  wire logic        [lir_pkg::FRAC_BITS-1:0]   frac,
    output logic signed      [lir_pkg::SAMPLE_BITS-1:0] value
);

    localparam int unsigned SB        = lir_pkg::SAMPLE_BITS;
    localparam int unsigned FB        = lir_pkg::FRAC_BITS;
    localparam int unsigned PROD_BITS = SB + FB + 2;

    logic signed [SB:0]           diff;
    logic signed [PROD_BITS-1:0]  prod_next;
    logic signed [PROD_BITS-1:0]  prod_reg;
    logic        [PROD_BITS-1:0]  sum;

    assign diff      = {b[SB-1], b} - {a[SB-1], a};
    assign prod_next = $signed({1'b0, frac}) * diff;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
        end
    end

    // a stays put while the product is in flight
    assign sum   = {{2{a[SB-1]}}, a, {FB{1'b0}}} + prod_reg
                 + PROD_BITS'(lir_pkg::ONE_Q16 / 2);
    assign value = sum[SB+FB-1:FB];

endmodule

`default_nettype wire

>>> sv/linear_interp_resampler.sv
// Sequence: an item is accepted, then a candidate check; each interpolated result takes
//   a multiply, then a round and place; a last position step and the run_last release
//   end the item.
// End of stream: the last sample is repeated, then the held one is released.
// Throughput: one item at a time; src_stall is high until the item's results are queued;
//   output stalls hold the unit. Reset (rst_n, async, active low): step 1.0, stream cleared.
`default_nettype none

module linear_interp_resampler #(
    parameter int unsigned MAX_RATIO = lir_pkg::MAX_RATIO
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // input channel
    input  wire logic                               src_valid,
    output logic                                    src_stall,
    input  wire lir_pkg::in_item_t                  src_item,
    // output channel
    output logic                                    dst_valid,
    input  wire logic                               dst_stall,
    output lir_pkg::out_item_t                      dst_item,
    // phase_step register
    input  wire logic                               cfg_we,
    input  wire logic [lir_pkg::CFG_BITS-1:0]       cfg_data
);

    localparam int unsigned SB        = lir_pkg::SAMPLE_BITS;
    localparam int unsigned FB        = lir_pkg::FRAC_BITS;
    localparam int unsigned STEP_LO   = lir_pkg::ONE_Q16 / MAX_RATIO;
    localparam int unsigned STEP_HI   = lir_pkg::ONE_Q16 * MAX_RATIO;
    localparam int unsigned STEP_BITS = $clog2(STEP_HI + 1);
    localparam int unsigned CMP_BITS  = (STEP_BITS > lir_pkg::CFG_BITS) ?
                                        STEP_BITS : lir_pkg::CFG_BITS;
    // position never exceeds one plus the largest step
    localparam int unsigned POS_BITS  = STEP_BITS + 1;
    localparam int unsigned TAIL_BITS = POS_BITS + 2;
    // signed distance of a candidate to its existence bound, times two
    localparam int unsigned WAIT_BITS = STEP_BITS + 3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CAND,
        S_MUL,
        S_EMIT,
        S_TAIL,
        S_FINISH
    } state_t;

    state_t                         state_reg,      state_next;
    logic [lir_pkg::CFG_BITS-1:0]   phase_step_reg, phase_step_next;
    logic [STEP_BITS-1:0]           step_reg,       step_next;
    logic signed [SB-1:0]           prev_reg,       prev_next;
    logic                           have_prev_reg,  have_prev_next;
    logic [POS_BITS-1:0]            pos_reg,        pos_next;
    logic                           emitted_reg,    emitted_next;
    logic                           held_valid_reg, held_valid_next;
    logic signed [SB-1:0]           held_value_reg, held_value_next;
    logic                           cand_valid_reg, cand_valid_next;
    logic signed [SB-1:0]           cand_value_reg, cand_value_next;
    logic signed [WAIT_BITS-1:0]    cand_wait_reg,  cand_wait_next;
    logic signed [SB-1:0]           x_reg,          x_next;
    logic                           last_reg,       last_next;
    logic                           pend_valid_reg, pend_valid_next;
    logic signed [SB-1:0]           pend_value_reg, pend_value_next;
    logic                           pend_done_reg,  pend_done_next;
    logic                           out_valid_reg,  out_valid_next;
    lir_pkg::out_item_t             out_item_reg,   out_item_next;

    logic [CMP_BITS-1:0]            step_ext;
    logic [STEP_BITS-1:0]           step_clamped;
    logic signed [SB-1:0]           interp_value;
    logic                           mul_load;
    logic signed [WAIT_BITS-1:0]    emit_wait;
    logic signed [WAIT_BITS-1:0]    wait_dec;
    logic                           emit_wait_le0;
    logic                           wait_dec_le0;
    logic [TAIL_BITS-1:0]           tail_sum;
    logic                           tail_more;
    logic [POS_BITS-1:0]            pos_stepped;
    logic                           out_free;
    logic                           emit_ok;
    logic                           conf_go;
    logic                           do_confirm;
    logic signed [SB-1:0]           confirm_val;
    logic                           do_put;
    logic signed [SB-1:0]           put_value;
    logic                           put_done;

    // step saturates into the supported ratio range
    always_comb
    begin
        step_ext = CMP_BITS'(phase_step_reg);
        if (step_ext < CMP_BITS'(STEP_LO))
        begin
            step_clamped = STEP_BITS'(STEP_LO);
        end
        else if (step_ext > CMP_BITS'(STEP_HI))
        begin
            step_clamped = STEP_BITS'(STEP_HI);
        end
        else
        begin
            step_clamped = STEP_BITS'(step_ext);
        end
    end

    lir_interp u_interp (
        .clk   (clk),
        .load  (mul_load),
        .a     (prev_reg),
        .b     (x_reg),
        .frac  (pos_reg[FB-1:0]),
        .value (interp_value)
    );

    // 2*pos + step - 4.0 : a candidate exists only once this is used up
    assign emit_wait     = $signed(WAIT_BITS'({pos_reg, 1'b0}))
                         + $signed(WAIT_BITS'(step_reg))
                         - $signed(WAIT_BITS'(4 * lir_pkg::ONE_Q16));
    assign wait_dec      = cand_wait_reg - $signed(WAIT_BITS'(2 * lir_pkg::ONE_Q16));
    assign emit_wait_le0 = emit_wait[WAIT_BITS-1] || (emit_wait == '0);
    assign wait_dec_le0  = wait_dec[WAIT_BITS-1] || (wait_dec == '0);

    // tail outputs exist while (pos + step/2) <= 1.0
    assign tail_sum    = TAIL_BITS'({pos_reg, 1'b0}) + TAIL_BITS'(step_reg);
    assign tail_more   = !emitted_reg || (tail_sum <= TAIL_BITS'(2 * lir_pkg::ONE_Q16));
    assign pos_stepped = pos_reg + POS_BITS'(step_reg);

    // output register can load this cycle
    assign out_free = !out_valid_reg || !dst_stall;
    // lookahead slot can take a new result
    assign emit_ok  = !pend_valid_reg || out_free;
    // a confirm pushes the held result out only if one is held
    assign conf_go  = !held_valid_reg || emit_ok;

    always_comb
    begin
        state_next      = state_reg;
        phase_step_next = phase_step_reg;
        step_next       = step_reg;
        prev_next       = prev_reg;
        have_prev_next  = have_prev_reg;
        pos_next        = pos_reg;
        emitted_next    = emitted_reg;
        held_valid_next = held_valid_reg;
        held_value_next = held_value_reg;
        cand_valid_next = cand_valid_reg;
        cand_value_next = cand_value_reg;
        cand_wait_next  = cand_wait_reg;
        x_next          = x_reg;
        last_next       = last_reg;
        pend_valid_next = pend_valid_reg;
        pend_value_next = pend_value_reg;
        pend_done_next  = pend_done_reg;
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;
        mul_load        = 1'b0;
        do_confirm      = 1'b0;
        confirm_val     = held_value_reg;
        do_put          = 1'b0;
        put_value       = held_value_reg;
        put_done        = 1'b0;

        if (out_valid_reg && !dst_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            phase_step_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (src_valid)
                begin
                    x_next    = src_item.sample_in;
                    last_next = src_item.stream_last;
                    if (!have_prev_reg)
                    begin
                        // first item of a stream: latch step, nothing to interpolate yet
                        step_next      = step_clamped;
                        prev_next      = src_item.sample_in;
                        have_prev_next = 1'b1;
                        pos_next       = '0;
                        state_next     = src_item.stream_last ? S_TAIL : S_FINISH;
                    end
                    else
                    begin
                        state_next = S_CAND;
                    end
                end
            end

            S_CAND:
            begin
                // one more sample seen: the pending candidate may now be proven
                if (!cand_valid_reg)
                begin
                    state_next = S_MUL;
                end
                else if (wait_dec_le0)
                begin
                    if (conf_go)
                    begin
                        do_confirm      = 1'b1;
                        confirm_val     = cand_value_reg;
                        cand_valid_next = 1'b0;
                        cand_wait_next  = wait_dec;
                        state_next      = S_MUL;
                    end
                end
                else
                begin
                    cand_wait_next = wait_dec;
                    state_next     = S_MUL;
                end
            end

            S_MUL:
            begin
                if (pos_reg < POS_BITS'(lir_pkg::ONE_Q16))
                begin
                    mul_load   = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    pos_next   = pos_reg - POS_BITS'(lir_pkg::ONE_Q16);
                    prev_next  = x_reg;
                    state_next = last_reg ? S_TAIL : S_FINISH;
                end
            end

            S_EMIT:
            begin
                if (!emitted_reg || emit_wait_le0)
                begin
                    if (conf_go)
                    begin
                        do_confirm   = 1'b1;
                        confirm_val  = interp_value;
                        emitted_next = 1'b1;
                        pos_next     = pos_stepped;
                        state_next   = S_MUL;
                    end
                end
                else if (cand_valid_reg)
                begin
                    // older candidate is superseded, so it must exist
                    if (conf_go)
                    begin
                        do_confirm      = 1'b1;
                        confirm_val     = cand_value_reg;
                        cand_value_next = interp_value;
                        cand_wait_next  = emit_wait;
                        emitted_next    = 1'b1;
                        pos_next        = pos_stepped;
                        state_next      = S_MUL;
                    end
                end
                else
                begin
                    cand_valid_next = 1'b1;
                    cand_value_next = interp_value;
                    cand_wait_next  = emit_wait;
                    emitted_next    = 1'b1;
                    pos_next        = pos_stepped;
                    state_next      = S_MUL;
                end
            end

            S_TAIL:
            begin
                // end of stream: repeat the last sample, then release the held one as done
                if (tail_more)
                begin
                    if (conf_go)
                    begin
                        do_confirm   = 1'b1;
                        confirm_val  = prev_reg;
                        emitted_next = 1'b1;
                        pos_next     = pos_stepped;
                    end
                end
                else if (!held_valid_reg || emit_ok)
                begin
                    if (held_valid_reg)
                    begin
                        do_put    = 1'b1;
                        put_value = held_value_reg;
                        put_done  = 1'b1;
                    end
                    prev_next       = '0;
                    have_prev_next  = 1'b0;
                    pos_next        = '0;
                    emitted_next    = 1'b0;
                    held_valid_next = 1'b0;
                    cand_valid_next = 1'b0;
                    state_next      = S_FINISH;
                end
            end

            S_FINISH:
            begin
                // last result of this item carries run_last
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next               = 1'b1;
                    out_item_next.sample_out     = pend_value_reg;
                    out_item_next.run_last       = 1'b1;
                    out_item_next.stream_done    = pend_done_reg;
                    pend_valid_next              = 1'b0;
                    state_next                   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // confirm: the held result goes out, the new one is held
        if (do_confirm)
        begin
            if (held_valid_reg)
            begin
                do_put    = 1'b1;
                put_value = held_value_reg;
                put_done  = 1'b0;
            end
            held_value_next = confirm_val;
            held_valid_next = 1'b1;
        end

        // put: lookahead slot moves on to the output register
        if (do_put)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next            = 1'b1;
                out_item_next.sample_out  = pend_value_reg;
                out_item_next.run_last    = 1'b0;
                out_item_next.stream_done = pend_done_reg;
            end
            pend_valid_next = 1'b1;
            pend_value_next = put_value;
            pend_done_next  = put_done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_step_reg <= lir_pkg::CFG_BITS'(lir_pkg::STEP_RESET);
            step_reg       <= STEP_BITS'(lir_pkg::STEP_RESET);
            prev_reg       <= '0;
            have_prev_reg  <= 1'b0;
            pos_reg        <= '0;
            emitted_reg    <= 1'b0;
            held_valid_reg <= 1'b0;
            held_value_reg <= '0;
            cand_valid_reg <= 1'b0;
            cand_value_reg <= '0;
            cand_wait_reg  <= '0;
            x_reg          <= '0;
            last_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_value_reg <= '0;
            pend_done_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_item_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_step_reg <= phase_step_next;
            step_reg       <= step_next;
            prev_reg       <= prev_next;
            have_prev_reg  <= have_prev_next;
            pos_reg        <= pos_next;
            emitted_reg    <= emitted_next;
            held_valid_reg <= held_valid_next;
            held_value_reg <= held_value_next;
            cand_valid_reg <= cand_valid_next;
            cand_value_reg <= cand_value_next;
            cand_wait_reg  <= cand_wait_next;
            x_reg          <= x_next;
            last_reg       <= last_next;
            pend_valid_reg <= pend_valid_next;
            pend_value_reg <= pend_value_next;
            pend_done_reg  <= pend_done_next;
            out_valid_reg  <= out_valid_next;
            out_item_reg   <= out_item_next;
        end
    end

    assign src_stall = (state_reg != S_IDLE);
    assign dst_valid = out_valid_reg;
    assign dst_item  = out_item_reg;

endmodule

`default_nettype wire
